// ===== hdl/psd_pkg.sv =====
`timescale 1ns / 1ps
// psd_pkg: shared types for the point to segment distance pipeline
// no dependencies; used by the divider cell and the top level

package psd_pkg;

	// how the projection factor is formed for one beat
	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_FULL = 2'd1,
		MODE_DIV  = 2'd2
	} mode_t;

endpackage

// ===== hdl/psd_if.sv =====
`timescale 1ns / 1ps
// psd_req_if and psd_rsp_if: valid/ready channels of the distance block
// no dependencies

interface psd_req_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] query_x;
	logic signed [W-1:0] query_y;
	logic signed [W-1:0] query_z;
	logic signed [W-1:0] start_x;
	logic signed [W-1:0] start_y;
	logic signed [W-1:0] start_z;
	logic signed [W-1:0] end_x;
	logic signed [W-1:0] end_y;
	logic signed [W-1:0] end_z;

	modport source (output valid, query_x, query_y, query_z, start_x, start_y, start_z,
		end_x, end_y, end_z, input ready);
	modport sink (input valid, query_x, query_y, query_z, start_x, start_y, start_z,
		end_x, end_y, end_z, output ready);
endinterface

interface psd_rsp_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W:0]   distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface

// ===== hdl/point_segment_distance_top.sv =====
`timescale 1ns / 1ps
// point_segment_distance_top: pipelined point to 3d segment distance
// depends on psd_pkg, psd_if, psd_div_cell, psd_sqrt_cell
//
// Usage:
// - req carries a query point and the two segment ends, signed fixed point
//   with FRAC_BITS fraction bits; rsp returns one distance beat per request
//   beat, unsigned, COORD_WIDTH+1 bits, same fraction bits, in order.
// - one beat per cycle unless rsp stalls; the whole datapath is one pipeline.
// - a request beat passes the difference, product and sum registers, a chain
//   of FRAC_BITS divider cells (one quotient bit each), the scaled
//   direction, residual, squared residual and squared distance registers,
//   COORD_WIDTH+2 square root cells (one root bit each) and the output
//   register on its way to the response beat.
// - reset clears all valid bits; the pipeline starts empty.
// - a stalled rsp freezes every stage at once; req.ready drops in the same
//   cycle and no beat is lost or duplicated.

module point_segment_distance_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	psd_req_if.sink   req,
	psd_rsp_if.source rsp
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int EW   = CW + 1;
	localparam int PW   = 2 * CW + 2;
	localparam int LW   = 2 * CW + 4;
	localparam int SIDE = 6 * EW;
	localparam int TPW  = EW + F + 2;
	localparam int RW   = CW + 3;
	localparam int QSW  = 2 * RW;
	localparam int SW   = 2 * CW + 4;
	localparam int RB   = CW + 2;

	logic en;
	logic out_valid_q;
	logic [CW:0] out_dist_q;

	// global advance: move when the output is free or being taken
	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	// stage 1: differences
	logic                 v_s1;
	logic signed [EW-1:0] ex_s1, ey_s1, ez_s1, dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= EW'(req.query_x) - EW'(req.start_x);
			ey_s1 <= EW'(req.query_y) - EW'(req.start_y);
			ez_s1 <= EW'(req.query_z) - EW'(req.start_z);
			dx_s1 <= EW'(req.end_x) - EW'(req.start_x);
			dy_s1 <= EW'(req.end_y) - EW'(req.start_y);
			dz_s1 <= EW'(req.end_z) - EW'(req.start_z);
		end
	end

	// stage 2: per-axis products
	logic                 v_s2;
	logic signed [PW-1:0] edx_s2, edy_s2, edz_s2, ddx_s2, ddy_s2, ddz_s2;
	logic signed [EW-1:0] ex_s2, ey_s2, ez_s2, dx_s2, dy_s2, dz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edx_s2 <= PW'(ex_s1) * PW'(dx_s1);
			edy_s2 <= PW'(ey_s1) * PW'(dy_s1);
			edz_s2 <= PW'(ez_s1) * PW'(dz_s1);
			ddx_s2 <= PW'(dx_s1) * PW'(dx_s1);
			ddy_s2 <= PW'(dy_s1) * PW'(dy_s1);
			ddz_s2 <= PW'(dz_s1) * PW'(dz_s1);
			ex_s2  <= ex_s1;
			ey_s2  <= ey_s1;
			ez_s2  <= ez_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
		end
	end

	// stage 3: dot product and squared length
	logic                 v_s3;
	logic signed [LW-1:0] dot_s3, len2_s3;
	logic [SIDE-1:0]      side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3  <= LW'(edx_s2) + LW'(edy_s2) + LW'(edz_s2);
			len2_s3 <= LW'(ddx_s2) + LW'(ddy_s2) + LW'(ddz_s2);
			side_s3 <= {ex_s2, ey_s2, ez_s2, dx_s2, dy_s2, dz_s2};
		end
	end

	// classify the projection and seed the divider
	psd_pkg::mode_t mode0;
	logic [LW-1:0]  rem0;

	always_comb begin
		if (len2_s3 == '0 || dot_s3 <= 0) begin
			mode0 = psd_pkg::MODE_ZERO;
		end else if (dot_s3 >= len2_s3) begin
			mode0 = psd_pkg::MODE_FULL;
		end else begin
			mode0 = psd_pkg::MODE_DIV;
		end
		rem0 = (mode0 == psd_pkg::MODE_DIV) ? dot_s3 : '0;
	end

	// divider chain, one quotient bit per cell
	logic           dv   [F+1];
	psd_pkg::mode_t dmode[F+1];
	logic [LW-1:0]  dlen [F+1];
	logic [LW-1:0]  drem [F+1];
	logic [F-1:0]   dquo [F+1];
	logic [SIDE-1:0] dside[F+1];

	assign dv[0]    = v_s3;
	assign dmode[0] = mode0;
	assign dlen[0]  = len2_s3;
	assign drem[0]  = rem0;
	assign dquo[0]  = '0;
	assign dside[0] = side_s3;

	for (genvar i = 0; i < F; i++) begin : g_div
		psd_div_cell #(.LW(LW), .QW(F), .SIDE(SIDE)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(dv[i]),
			.mode_i (dmode[i]),
			.len2_i (dlen[i]),
			.rem_i  (drem[i]),
			.quo_i  (dquo[i]),
			.side_i (dside[i]),
			.valid_o(dv[i+1]),
			.mode_o (dmode[i+1]),
			.len2_o (dlen[i+1]),
			.rem_o  (drem[i+1]),
			.quo_o  (dquo[i+1]),
			.side_o (dside[i+1])
		);
	end

	// projection factor, unsigned Q1.F
	logic [F:0] tfac;
	logic signed [EW-1:0] ex_d, ey_d, ez_d, dx_d, dy_d, dz_d;

	always_comb begin
		case (dmode[F])
			psd_pkg::MODE_FULL: tfac = (F+1)'(1) << F;
			psd_pkg::MODE_DIV:  tfac = {1'b0, dquo[F]};
			default:            tfac = '0;
		endcase
		{ex_d, ey_d, ez_d, dx_d, dy_d, dz_d} = dside[F];
	end

	// stage 5: scaled direction
	logic                  v_s5;
	logic signed [TPW-1:0] px_s5, py_s5, pz_s5;
	logic signed [EW-1:0]  ex_s5, ey_s5, ez_s5;
	logic signed [TPW-1:0] tsgn;

	assign tsgn = TPW'($signed({1'b0, tfac}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv[F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= TPW'(dx_d) * tsgn;
			py_s5 <= TPW'(dy_d) * tsgn;
			pz_s5 <= TPW'(dz_d) * tsgn;
			ex_s5 <= ex_d;
			ey_s5 <= ey_d;
			ez_s5 <= ez_d;
		end
	end

	// stage 6: residual, offset rounds toward minus infinity
	logic                  v_s6;
	logic signed [RW-1:0]  rx_s6, ry_s6, rz_s6;
	logic signed [TPW-1:0] ox, oy, oz;

	always_comb begin
		ox = px_s5 >>> F;
		oy = py_s5 >>> F;
		oz = pz_s5 >>> F;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s6 <= RW'(ex_s5) - RW'(ox);
			ry_s6 <= RW'(ey_s5) - RW'(oy);
			rz_s6 <= RW'(ez_s5) - RW'(oz);
		end
	end

	// stage 7: squared residuals
	logic                  v_s7;
	logic signed [QSW-1:0] sx_s7, sy_s7, sz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s7 <= QSW'(rx_s6) * QSW'(rx_s6);
			sy_s7 <= QSW'(ry_s6) * QSW'(ry_s6);
			sz_s7 <= QSW'(rz_s6) * QSW'(rz_s6);
		end
	end

	// stage 8: squared distance
	logic          v_s8;
	logic [SW-1:0] sum_s8;
	logic [QSW-1:0] sum_full;

	assign sum_full = sx_s7 + sy_s7 + sz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8 <= sum_full[SW-1:0];
		end
	end

	// square root chain, one root bit per cell
	logic          sv   [RB+1];
	logic [SW-1:0] srad [RB+1];
	logic [RB+1:0] srem [RB+1];
	logic [RB-1:0] sroot[RB+1];

	assign sv[0]    = v_s8;
	assign srad[0]  = sum_s8;
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		psd_sqrt_cell #(.SW(SW), .RB(RB)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(sv[j]),
			.rad_i  (srad[j]),
			.rem_i  (srem[j]),
			.root_i (sroot[j]),
			.valid_o(sv[j+1]),
			.rad_o  (srad[j+1]),
			.rem_o  (srem[j+1]),
			.root_o (sroot[j+1])
		);
	end

	// output register with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sv[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dist_q <= sroot[RB][RB-1] ? '1 : sroot[RB][CW:0];
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.distance = out_dist_q;

endmodule

// ===== hdl/psd_div_cell.sv =====
`timescale 1ns / 1ps
// psd_div_cell: one restoring division step, one quotient bit per cell
// depends on psd_pkg

module psd_div_cell #(
	parameter int LW   = 68,
	parameter int QW   = 16,
	parameter int SIDE = 198
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_i,
	input  psd_pkg::mode_t        mode_i,
	input  logic [LW-1:0]         len2_i,
	input  logic [LW-1:0]         rem_i,
	input  logic [QW-1:0]         quo_i,
	input  logic [SIDE-1:0]       side_i,
	output logic                  valid_o,
	output psd_pkg::mode_t        mode_o,
	output logic [LW-1:0]         len2_o,
	output logic [LW-1:0]         rem_o,
	output logic [QW-1:0]         quo_o,
	output logic [SIDE-1:0]       side_o
);

	logic                 valid_q;
	psd_pkg::mode_t       mode_q;
	logic [LW-1:0]        len2_q;
	logic [LW-1:0]        rem_q;
	logic [QW-1:0]        quo_q;
	logic [SIDE-1:0]      side_q;
	logic [LW:0]          rem2;
	logic [LW:0]          diff;
	logic                 ge;

	// shift remainder and trial subtract
	always_comb begin
		rem2 = {rem_i, 1'b0};
		diff = rem2 - {1'b0, len2_i};
		ge   = (rem2 >= {1'b0, len2_i});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			mode_q <= mode_i;
			len2_q <= len2_i;
			rem_q  <= ge ? diff[LW-1:0] : rem2[LW-1:0];
			quo_q  <= {quo_i[QW-2:0], ge};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign mode_o  = mode_q;
	assign len2_o  = len2_q;
	assign rem_o   = rem_q;
	assign quo_o   = quo_q;
	assign side_o  = side_q;

endmodule

// ===== hdl/psd_sqrt_cell.sv =====
`timescale 1ns / 1ps
// psd_sqrt_cell: one digit-by-digit square root step, one root bit per cell
// no dependencies

module psd_sqrt_cell #(
	parameter int SW = 68,
	parameter int RB = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [SW-1:0] rad_i,
	input  logic [RB+1:0] rem_i,
	input  logic [RB-1:0] root_i,
	output logic          valid_o,
	output logic [SW-1:0] rad_o,
	output logic [RB+1:0] rem_o,
	output logic [RB-1:0] root_o
);

	logic          valid_q;
	logic [SW-1:0] rad_q;
	logic [RB+1:0] rem_q;
	logic [RB-1:0] root_q;
	logic [RB+1:0] rem_n;
	logic [RB+1:0] trial;
	logic          ge;

	// bring down the next two radicand bits and try the next root bit
	always_comb begin
		rem_n = {rem_i[RB-1:0], rad_i[SW-1:SW-2]};
		trial = {root_i, 2'b01};
		ge    = (rem_n >= trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_i[SW-3:0], 2'b00};
			rem_q  <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_i[RB-2:0], ge};
		end
	end

	assign valid_o = valid_q;
	assign rad_o   = rad_q;
	assign rem_o   = rem_q;
	assign root_o  = root_q;

endmodule
